// ===== sv/stc_pkg.sv =====
// shared types and constants for the slot table with rotate and compacted read
`timescale 1ns / 1ps
package stc_pkg;

	// fixed field widths of the item and result beats
	localparam int unsigned OP_W     = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned INDEX_W  = 4;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned BIT_IW   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_ROTATE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_REMOVE,
		S_ROTATE,
		S_ROT_DONE,
		S_READ
	} state_t;

	// which result the output register is loaded with
	typedef enum logic [2:0] {
		RES_INSERT,
		RES_FULL,
		RES_REMOVE,
		RES_PLAIN,
		RES_READ
	} res_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      idx_inc;
		logic      pass_set;
		logic      wr_insert;
		logic      clr_used;
		logic      rot_step;
		logic      emit;
		res_kind_t kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_used;
		logic idx_last;
		logic pass;
		logic out_free;
		logic bit_last;
	} dp_stat_t;

endpackage

// ===== sv/stc_ifs.sv =====
// item and result channel interfaces
`timescale 1ns / 1ps
interface stc_item_if;
	import stc_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] value;
	logic [INDEX_W-1:0] slot_index;
	logic [COUNT_W-1:0] rotate_count;

	modport source (output valid, operation, value, slot_index, rotate_count, input ready);
	modport sink (input valid, operation, value, slot_index, rotate_count, output ready);
endinterface

interface stc_result_if;
	import stc_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  slot;
	logic [VALUE_W-1:0]  element;
	logic                occupied;
	logic                last;

	modport source (output valid, status, slot, element, occupied, last, input ready);
	modport sink (input valid, status, slot, element, occupied, last, output ready);
endinterface

// ===== sv/slot_table_rotate_compact.sv =====
// top level of the slot table with insert, remove, rotate and compacted read
`timescale 1ns / 1ps
// Slot table of SLOTS entries, each a DATA_WIDTH value and an occupied flag.
// The item channel carries operation, value, slot_index and rotate_count; a
// beat is taken whenever the controller is idle, also while a result beat
// still waits in the output register. The result channel carries status,
// slot, element, occupied and last; last marks the final beat of an item.
// Steps per item, the sequencer handling one item at a time:
//   insert:  scan one slot per cycle for the lowest free one, holding at
//            the free or last slot while the output register is busy
//   remove:  clear the slot if in range and give the result
//   rotate:  one conditional rotate by (2**b) mod SLOTS per count bit,
//            then give the result
//   read:    two scans over the table, SLOTS result beats
// A result is registered and stays until taken; while the receiver stalls,
// the scan holds at the slot that has a beat to give. Reset clears the whole
// table and output valid flag at once; the block takes items right after it.
module slot_table_rotate_compact #(
	parameter int unsigned SLOTS      = 10,
	parameter int unsigned DATA_WIDTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	stc_item_if.sink     item,
	stc_result_if.source result
);
	import stc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     item_ready;

	assign item.ready = item_ready;

	// controller
	stc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (op_t'(item.operation)),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath
	stc_dp #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_value        (item.value),
		.item_slot_index   (item.slot_index),
		.item_rotate_count (item.rotate_count),
		.cmd               (cmd),
		.stat              (stat),
		.result            (result)
	);

endmodule

// ===== sv/stc_ctrl.sv =====
// controller state machine sequencing insert, remove, rotate and compacted read
`timescale 1ns / 1ps
module stc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  stc_pkg::op_t     item_op,
	output logic             item_ready,
	input  stc_pkg::dp_stat_t stat,
	output stc_pkg::dp_cmd_t  cmd
);
	import stc_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   read_match;

	// compacted read takes occupied slots in the first pass, free ones in the second
	assign read_match = (stat.slot_used == !stat.pass);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					unique case (item_op)
						OP_INSERT: state_nxt = S_INSERT;
						OP_REMOVE: state_nxt = S_REMOVE;
						OP_ROTATE: state_nxt = S_ROTATE;
						OP_READ:   state_nxt = S_READ;
						default:   state_nxt = S_IDLE;
					endcase
				end
			end
			S_INSERT: begin
				if ((!stat.slot_used || stat.idx_last) && stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_REMOVE: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_ROTATE: begin
				if (stat.bit_last) begin
					state_nxt = S_ROT_DONE;
				end
			end
			S_ROT_DONE: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_READ: begin
				if ((!read_match || stat.out_free) && stat.idx_last && stat.pass) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		cmd.kind   = RES_PLAIN;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			S_INSERT: begin
				if (!stat.slot_used) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.kind      = RES_INSERT;
						cmd.wr_insert = 1'b1;
					end
				end else if (stat.idx_last) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.kind = RES_FULL;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_REMOVE: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = RES_REMOVE;
					cmd.clr_used = 1'b1;
				end
			end
			S_ROTATE: begin
				cmd.rot_step = 1'b1;
			end
			S_ROT_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = RES_PLAIN;
				end
			end
			S_READ: begin
				if (!read_match || stat.out_free) begin
					cmd.emit = read_match;
					cmd.kind = RES_READ;
					if (!stat.idx_last) begin
						cmd.idx_inc = 1'b1;
					end else if (!stat.pass) begin
						cmd.pass_set = 1'b1;
					end
				end
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/stc_dp.sv =====
// datapath: slot storage, scan counters, rotate network and output register
`timescale 1ns / 1ps
module stc_dp #(
	parameter int unsigned SLOTS      = 10,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [stc_pkg::VALUE_W-1:0] item_value,
	input  logic [stc_pkg::INDEX_W-1:0] item_slot_index,
	input  logic [stc_pkg::COUNT_W-1:0] item_rotate_count,
	input  stc_pkg::dp_cmd_t            cmd,
	output stc_pkg::dp_stat_t           stat,
	stc_result_if.source                result
);
	import stc_pkg::*;

	localparam int unsigned IW     = $clog2(SLOTS);
	localparam int unsigned STEPS  = 1 << BIT_IW;
	localparam int unsigned CMP_W  = INDEX_W + 1;

	// slot storage
	logic [DATA_WIDTH-1:0] val_q [SLOTS];
	logic [SLOTS-1:0]      used_q;

	// operands of the item in progress
	logic [VALUE_W-1:0]  value_q;
	logic [INDEX_W-1:0]  sidx_q;
	logic [COUNT_W-1:0]  cnt_q;

	// scan state
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       k_q;
	logic                pass_q;
	logic [BIT_IW-1:0]   bit_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [INDEX_W-1:0]  out_slot_q;
	logic [VALUE_W-1:0]  out_element_q;
	logic                out_occ_q;
	logic                out_last_q;

	logic                out_free;
	logic                index_bad;
	logic [IW-1:0]       rem_idx;
	logic [63:0]         cur_wide;
	logic [63:0]         in_wide;
	logic [DATA_WIDTH-1:0] rot_v [STEPS][SLOTS];
	logic [SLOTS-1:0]      rot_u [STEPS];

	assign out_free  = !out_valid_q || result.ready;
	assign index_bad = CMP_W'(sidx_q) >= CMP_W'(SLOTS);
	assign rem_idx   = sidx_q[IW-1:0];
	assign cur_wide  = 64'(val_q[idx_q]);
	assign in_wide   = 64'(value_q);

	// rotate right by (2**b) mod SLOTS, one candidate per count bit
	for (genvar b = 0; b < STEPS; b++) begin : g_rot
		localparam int unsigned AMT = (1 << b) % SLOTS;
		for (genvar j = 0; j < SLOTS; j++) begin : g_slot
			localparam int unsigned SRC = (j + SLOTS - AMT) % SLOTS;
			assign rot_v[b][j] = val_q[SRC];
			assign rot_u[b][j] = used_q[SRC];
		end
	end

	// status toward the controller
	always_comb begin
		stat           = '0;
		stat.slot_used = used_q[idx_q];
		stat.idx_last  = (idx_q == IW'(SLOTS - 1));
		stat.pass      = pass_q;
		stat.out_free  = out_free;
		stat.bit_last  = (bit_q == BIT_IW'(STEPS - 1));
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			k_q    <= '0;
			pass_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				k_q    <= '0;
				pass_q <= 1'b0;
				bit_q  <= '0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + IW'(1);
				end
				if (cmd.pass_set) begin
					pass_q <= 1'b1;
					idx_q  <= '0;
				end
				if (cmd.rot_step) begin
					bit_q <= bit_q + BIT_IW'(1);
				end
				if (cmd.emit && (cmd.kind == RES_READ)) begin
					k_q <= k_q + IW'(1);
				end
			end
		end
	end

	// operand payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= item_value;
			sidx_q  <= item_slot_index;
			cnt_q   <= item_rotate_count;
		end
	end

	// slot table: insert, remove and rotate steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				val_q[i] <= '0;
			end
		end else begin
			if (cmd.wr_insert) begin
				used_q[idx_q] <= 1'b1;
				val_q[idx_q]  <= in_wide[DATA_WIDTH-1:0];
			end
			if (cmd.clr_used && !index_bad) begin
				used_q[rem_idx] <= 1'b0;
			end
			if (cmd.rot_step && cnt_q[bit_q]) begin
				used_q <= rot_u[bit_q];
				for (int i = 0; i < SLOTS; i++) begin
					val_q[i] <= rot_v[bit_q][i];
				end
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q  <= ST_OK;
			out_slot_q    <= '0;
			out_element_q <= '0;
			out_occ_q     <= 1'b0;
			out_last_q    <= 1'b1;
			case (cmd.kind)
				RES_INSERT: out_slot_q <= INDEX_W'(idx_q);
				RES_FULL:   out_status_q <= ST_FULL;
				RES_REMOVE: out_status_q <= index_bad ? ST_BAD_INDEX : ST_OK;
				RES_READ: begin
					out_slot_q    <= INDEX_W'(k_q);
					out_element_q <= cur_wide[VALUE_W-1:0];
					out_occ_q     <= !pass_q;
					out_last_q    <= (k_q == IW'(SLOTS - 1));
				end
				default: out_status_q <= ST_OK;
			endcase
		end
	end

	assign result.valid    = out_valid_q;
	assign result.status   = out_status_q;
	assign result.slot     = out_slot_q;
	assign result.element  = out_element_q;
	assign result.occupied = out_occ_q;
	assign result.last     = out_last_q;

endmodule

// ===== verif/tb_slot_table_rotate_compact.sv =====
// testbench for the slot table with insert, remove, rotate and compacted read
`timescale 1ns / 1ps
module tb_slot_table_rotate_compact;
	import stc_pkg::*;

	localparam int unsigned SLOTS       = 10;
	localparam int unsigned TAIL_ITEMS  = 40;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned DRAIN_WAIT  = 40;

	typedef struct {
		op_t                op;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] slot_index;
		logic [COUNT_W-1:0] rotate_count;
	} table_cmd_t;

	typedef struct {
		status_t            status;
		logic [INDEX_W-1:0] slot;
		logic [VALUE_W-1:0] element;
		logic               occupied;
		logic               last;
	} table_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	stc_item_if   item_ch ();
	stc_result_if result_ch ();

	slot_table_rotate_compact #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (VALUE_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// pending item beats and expected result beats
	table_cmd_t  cmd_q [$];
	table_beat_t beat_q [$];
	table_beat_t exp_beat;
	table_cmd_t  taken_cmd;

	// shadow copy of the table
	logic [VALUE_W-1:0] shadow_val [SLOTS];
	logic               shadow_used [SLOTS];

	int unsigned err_cnt, total_cmds, cmds_taken, beats_checked, idle_cycles;
	int unsigned send_gap, recv_gap, full_cnt, bad_cnt;
	int unsigned op_cnt [4];
	bit          recv_hold, cmd_took;
	op_t         last_op;

	always #1 clk = ~clk;

	task automatic report(input string msg);
		err_cnt++;
		$display("ERROR result beat %0d: %s", beats_checked, msg);
	endtask

	// apply one item to the shadow table and queue the beats it should give
	task automatic table_apply(input table_cmd_t c);
		logic [VALUE_W-1:0] rot_val [SLOTS];
		logic               rot_used [SLOTS];
		table_beat_t        b;
		int unsigned        amt, k, free_at;
		bit                 want;
		b.status   = ST_OK;
		b.slot     = '0;
		b.element  = '0;
		b.occupied = 1'b0;
		b.last     = 1'b1;
		op_cnt[c.op]++;
		case (c.op)
			OP_INSERT: begin
				free_at = SLOTS;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!shadow_used[i])
						free_at = i;
				if (free_at == SLOTS) begin
					b.status = ST_FULL;
					full_cnt++;
				end else begin
					shadow_used[free_at] = 1'b1;
					shadow_val[free_at]  = c.value;
					b.slot = INDEX_W'(free_at);
				end
				beat_q.push_back(b);
			end
			OP_REMOVE: begin
				if (c.slot_index >= SLOTS) begin
					b.status = ST_BAD_INDEX;
					bad_cnt++;
				end else begin
					shadow_used[c.slot_index] = 1'b0;
				end
				beat_q.push_back(b);
			end
			OP_ROTATE: begin
				amt = c.rotate_count % SLOTS;
				for (int i = 0; i < SLOTS; i++) begin
					rot_val[(i + amt) % SLOTS]  = shadow_val[i];
					rot_used[(i + amt) % SLOTS] = shadow_used[i];
				end
				shadow_val  = rot_val;
				shadow_used = rot_used;
				beat_q.push_back(b);
			end
			default: begin
				// occupied slots in order, then free ones
				k = 0;
				for (int p = 0; p < 2; p++) begin
					want = (p == 0);
					for (int i = 0; i < SLOTS; i++) begin
						if (shadow_used[i] == want) begin
							b.slot     = INDEX_W'(k);
							b.element  = shadow_val[i];
							b.occupied = want;
							b.last     = (k == SLOTS - 1);
							beat_q.push_back(b);
							k++;
						end
					end
				end
			end
		endcase
	endtask

	task automatic add_cmd(input op_t op, input logic [VALUE_W-1:0] v,
	                       input logic [INDEX_W-1:0] idx, input logic [COUNT_W-1:0] cnt);
		table_cmd_t c;
		c.op           = op;
		c.value        = v;
		c.slot_index   = idx;
		c.rotate_count = cnt;
		cmd_q.push_back(c);
	endtask

	// random item, mostly inserts and in-range removes to keep the table busy
	task automatic add_random_cmd();
		int unsigned r;
		logic [INDEX_W-1:0] idx;
		r = $urandom_range(0, 99);
		idx = INDEX_W'($urandom_range(0, 15));
		if (r < 40) begin
			add_cmd(OP_INSERT, $urandom(), idx, COUNT_W'($urandom_range(0, 255)));
		end else if (r < 70) begin
			if ($urandom_range(0, 99) < 85)
				idx = INDEX_W'($urandom_range(0, SLOTS - 1));
			else
				idx = INDEX_W'($urandom_range(SLOTS, 15));
			add_cmd(OP_REMOVE, $urandom(), idx, COUNT_W'($urandom_range(0, 255)));
		end else if (r < 82) begin
			add_cmd(OP_ROTATE, $urandom(), idx, COUNT_W'($urandom_range(0, 255)));
		end else begin
			add_cmd(OP_READ, $urandom(), idx, COUNT_W'($urandom_range(0, 255)));
		end
	endtask

	// item driver, changes at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && !cmd_took) begin
				// beat still offered, hold it
			end else if (send_gap != 0) begin
				send_gap--;
				item_ch.valid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				if (cmds_taken + TAIL_ITEMS < total_cmds && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 5);
					item_ch.valid <= 1'b0;
				end else begin
					item_ch.valid        <= 1'b1;
					item_ch.operation    <= cmd_q[0].op;
					item_ch.value        <= cmd_q[0].value;
					item_ch.slot_index   <= cmd_q[0].slot_index;
					item_ch.rotate_count <= cmd_q[0].rotate_count;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
			cmd_took = 1'b0;
		end
	end

	// result receiver, random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_hold) begin
				result_ch.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else if (cmds_taken + TAIL_ITEMS < total_cmds && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 5);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off, preferably right after a compacted read is taken
	initial begin
		recv_hold = 1'b0;
		@(posedge clk);
		while (!(cmds_taken >= 60 && (last_op == OP_READ || cmds_taken >= 120)))
			@(posedge clk);
		recv_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold = 1'b0;
	end

	// monitor: take item beats into the shadow table, check result beats, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				taken_cmd.op           = op_t'(item_ch.operation);
				taken_cmd.value        = item_ch.value;
				taken_cmd.slot_index   = item_ch.slot_index;
				taken_cmd.rotate_count = item_ch.rotate_count;
				table_apply(taken_cmd);
				last_op = taken_cmd.op;
				if (cmd_q.size() != 0)
					void'(cmd_q.pop_front());
				cmds_taken++;
				cmd_took = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (beat_q.size() == 0) begin
					report($sformatf("unexpected beat status %0d slot %0d element %h",
					                 result_ch.status, result_ch.slot, result_ch.element));
				end else begin
					exp_beat = beat_q.pop_front();
					if (result_ch.status !== exp_beat.status || result_ch.slot !== exp_beat.slot ||
					    result_ch.element !== exp_beat.element ||
					    result_ch.occupied !== exp_beat.occupied ||
					    result_ch.last !== exp_beat.last)
						report($sformatf("got st %0d slot %0d el %h occ %b last %b, want %0d %0d %h %b %b",
						                 result_ch.status, result_ch.slot, result_ch.element,
						                 result_ch.occupied, result_ch.last, exp_beat.status,
						                 exp_beat.slot, exp_beat.element, exp_beat.occupied,
						                 exp_beat.last));
				end
				beats_checked++;
			end
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.operation      = '0;
		item_ch.value          = '0;
		item_ch.slot_index     = '0;
		item_ch.rotate_count   = '0;
		result_ch.ready        = 1'b0;
		err_cnt = 0; total_cmds = 0; cmds_taken = 0; beats_checked = 0; idle_cycles = 0;
		send_gap = 0; recv_gap = 0; full_cnt = 0; bad_cnt = 0;
		cmd_took = 1'b0;
		last_op  = OP_INSERT;
		for (int i = 0; i < 4; i++)
			op_cnt[i] = 0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_val[i]  = '0;
			shadow_used[i] = 1'b0;
		end

		// directed: value extremes, fill to full, one insert too many
		add_cmd(OP_INSERT, 32'h0000_0000, 4'd0, 8'd0);
		add_cmd(OP_INSERT, 32'hFFFF_FFFF, 4'd15, 8'd255);
		for (int i = 0; i < SLOTS - 2; i++)
			add_cmd(OP_INSERT, $urandom(), 4'd0, 8'd0);
		add_cmd(OP_INSERT, 32'hDEAD_0001, 4'd0, 8'd0);
		add_cmd(OP_READ, 32'h0, 4'd0, 8'd0);
		// removes: edges, out of range, freeing a free slot
		add_cmd(OP_REMOVE, 32'h0, 4'd0, 8'd0);
		add_cmd(OP_REMOVE, 32'h0, 4'(SLOTS - 1), 8'd0);
		add_cmd(OP_REMOVE, 32'h0, 4'(SLOTS), 8'd0);
		add_cmd(OP_REMOVE, 32'h0, 4'd15, 8'd0);
		add_cmd(OP_REMOVE, 32'h0, 4'd0, 8'd0);
		// freed values must still show up among the free slots
		add_cmd(OP_READ, 32'h0, 4'd0, 8'd0);
		// rotate by zero, by the largest count, by a plain count
		add_cmd(OP_ROTATE, 32'h0, 4'd0, 8'd0);
		add_cmd(OP_ROTATE, 32'h0, 4'd0, 8'd255);
		add_cmd(OP_ROTATE, 32'h0, 4'd0, 8'd7);
		add_cmd(OP_READ, 32'h0, 4'd0, 8'd0);
		add_cmd(OP_INSERT, 32'h1234_5678, 4'd0, 8'd0);
		add_cmd(OP_READ, 32'h0, 4'd0, 8'd0);

		// random part with a fill run now and then to reach the full table
		for (int n = 0; n < 190; n++) begin
			if (n % 60 == 0)
				for (int j = 0; j < 12; j++)
					add_cmd(OP_INSERT, $urandom(), INDEX_W'($urandom_range(0, 15)),
					        COUNT_W'($urandom_range(0, 255)));
			add_random_cmd();
		end
		total_cmds = cmd_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_q.size() != 0 || beat_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d items: %0d insert, %0d remove, %0d rotate, %0d compacted read",
		         cmds_taken, op_cnt[OP_INSERT], op_cnt[OP_REMOVE], op_cnt[OP_ROTATE],
		         op_cnt[OP_READ]);
		$display("%0d result beats checked, %0d inserts on a full table, %0d bad-index removes",
		         beats_checked, full_cnt, bad_cnt);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
